>>> rtl/lags_pkg.sv
package lags_pkg;

    localparam int EXT_W = 7;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_EMIT    = 2'd1,
        KIND_ADVANCE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_WR_RD = 3'd1,
        ST_WR_WR = 3'd2,
        ST_EMIT  = 3'd3,
        ST_ADV   = 3'd4
    } state_t;

    typedef struct packed {
        logic load_item;
        logic use_item;
        logic rd_en;
        logic wr_en;
        logic clr_win;
        logic shift;
        logic below_zero;
        logic out_load;
        logic out_last;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  wr_in_range;
        logic  out_free;
    } stat_t;

endpackage

>>> rtl/lags_item_if.sv
interface lags_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [3:0] row;
    logic [3:0] col;
    logic       alive;

    modport source (output valid, output kind, output row, output col, output alive,
                    input ready);
    modport sink (input valid, input kind, input row, input col, input alive,
                  output ready);
endinterface

>>> rtl/lags_result_if.sv
interface lags_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  row_index;
    logic [15:0] row_bits;
    logic        last;

    modport source (output valid, output row_index, output row_bits, output last,
                    input ready);
    modport sink (input valid, input row_index, input row_bits, input last,
                  output ready);
endinterface

>>> rtl/lags_ctrl.sv
module lags_ctrl #(
    parameter int ROWS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid,
    output logic                          ready,
    input  lags_pkg::stat_t               st,
    output lags_pkg::cmd_t                cmd,
    output logic [$clog2(ROWS+2)-1:0]     cnt,
    output logic [$clog2(ROWS)-1:0]       ocnt
);
    import lags_pkg::*;

    localparam int CNT_W = $clog2(ROWS + 2);
    localparam int RW    = $clog2(ROWS);
    localparam logic [CNT_W-1:0] ROWS_C   = CNT_W'(ROWS);
    localparam logic [CNT_W-1:0] ROWS_END = CNT_W'(ROWS + 1);
    localparam logic [CNT_W-1:0] TWO_C    = CNT_W'(2);
    localparam logic [RW-1:0]    LAST_ROW = RW'(ROWS - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]    ocnt_reg, ocnt_next;
    logic             pend_reg, pend_next;
    logic             move, issue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ocnt_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ocnt_reg  <= ocnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ocnt_next  = ocnt_reg;
        pend_next  = pend_reg;
        ready      = 1'b0;
        cmd        = '0;
        move       = 1'b0;
        issue      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ready = 1'b1;
                if (valid)
                begin
                    cmd.load_item = 1'b1;
                    cnt_next      = '0;
                    ocnt_next     = '0;
                    pend_next     = 1'b0;
                    case (st.kind)
                        KIND_WRITE:
                        begin
                            if (st.wr_in_range)
                            begin
                                state_next = ST_WR_RD;
                            end
                        end
                        KIND_EMIT:
                        begin
                            state_next = ST_EMIT;
                        end
                        KIND_ADVANCE:
                        begin
                            cmd.clr_win = 1'b1;
                            state_next  = ST_ADV;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WR_RD:
            begin
                cmd.use_item = 1'b1;
                cmd.rd_en    = 1'b1;
                state_next   = ST_WR_WR;
            end
            ST_WR_WR:
            begin
                cmd.use_item = 1'b1;
                cmd.wr_en    = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_EMIT:
            begin
                move  = pend_reg && st.out_free;
                issue = (cnt_reg < ROWS_C) && (!pend_reg || move);
                cmd.rd_en    = issue;
                cmd.out_load = move;
                cmd.out_last = (ocnt_reg == LAST_ROW);
                if (issue)
                begin
                    cnt_next  = cnt_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                else if (move)
                begin
                    pend_next = 1'b0;
                end
                if (move)
                begin
                    ocnt_next = ocnt_reg + RW'(1);
                    if (ocnt_reg == LAST_ROW)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ADV:
            begin
                cmd.rd_en      = (cnt_reg < ROWS_C);
                cmd.shift      = (cnt_reg != '0);
                cmd.below_zero = (cnt_reg == ROWS_END);
                cmd.wr_en      = (cnt_reg >= TWO_C);
                if (cnt_reg == ROWS_END)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign cnt  = cnt_reg;
    assign ocnt = ocnt_reg;

`ifndef SYNTHESIS
    a_adv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADV |-> cnt_reg <= ROWS_END)
        else $error("advance sweep ran past its end");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && cmd.rd_en && pend_reg |-> cmd.out_load)
        else $error("emit read overwrote an unsent row");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> st.out_free)
        else $error("output register loaded while still full");

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && state_next == ST_IDLE |-> cnt_reg == ROWS_C && !pend_next)
        else $error("emit ended with rows still outstanding");
`endif

endmodule

>>> rtl/lags_datapath.sv
module lags_datapath #(
    parameter int ROWS = 16,
    parameter int COLS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [1:0]                    kind,
    input  logic [3:0]                    row,
    input  logic [3:0]                    col,
    input  logic                          alive,
    input  lags_pkg::cmd_t                cmd,
    input  logic [$clog2(ROWS+2)-1:0]     cnt,
    input  logic [$clog2(ROWS)-1:0]       ocnt,
    output lags_pkg::stat_t               st,
    lags_result_if.source                 result
);
    import lags_pkg::*;

    localparam int CNT_W = $clog2(ROWS + 2);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);

    logic [COLS-1:0] mem [ROWS];
    logic [ROWS-1:0] row_vld_reg;

    logic [3:0]      item_row_reg;
    logic [3:0]      item_col_reg;
    logic            item_alive_reg;

    logic [COLS-1:0] rd_raw_reg;
    logic            rd_vld_reg;
    logic [COLS-1:0] rd_data;

    logic [COLS-1:0] above_reg;
    logic [COLS-1:0] cur_reg;
    logic [COLS-1:0] below;
    logic [COLS-1:0] next_row;
    logic [COLS-1:0] mod_row;
    logic [COLS-1:0] wr_data;

    logic [RW-1:0]    rd_addr;
    logic [RW-1:0]    wr_addr;
    logic [RW-1:0]    item_ridx;
    logic [CW-1:0]    item_cidx;
    logic [EXT_W-1:0] row_ext;
    logic [EXT_W-1:0] col_ext;
    logic [EXT_W-1:0] irow_ext;
    logic [EXT_W-1:0] icol_ext;
    logic [CNT_W-1:0] cnt_m2;

    logic             out_valid_reg;
    logic [3:0]       out_idx_reg;
    logic [15:0]      out_bits_reg;
    logic             out_last_reg;
    logic [COLS+15:0] rd_wide;
    logic [RW+3:0]    ocnt_wide;

    assign row_ext  = EXT_W'(row);
    assign col_ext  = EXT_W'(col);
    assign irow_ext = EXT_W'(item_row_reg);
    assign icol_ext = EXT_W'(item_col_reg);
    assign item_ridx = irow_ext[RW-1:0];
    assign item_cidx = icol_ext[CW-1:0];
    assign cnt_m2    = cnt - CNT_W'(2);

    assign st.kind        = kind_t'(kind);
    assign st.wr_in_range = (row_ext < EXT_W'(ROWS)) && (col_ext < EXT_W'(COLS));
    assign st.out_free    = !out_valid_reg || result.ready;

    assign rd_addr = cmd.use_item ? item_ridx : cnt[RW-1:0];
    assign wr_addr = cmd.use_item ? item_ridx : cnt_m2[RW-1:0];
    assign rd_data = rd_vld_reg ? rd_raw_reg : '0;
    assign below   = cmd.below_zero ? '0 : rd_data;

    always_comb
    begin
        mod_row            = rd_data;
        mod_row[item_cidx] = item_alive_reg;
    end

    always_comb
    begin
        logic [COLS+1:0] ap;
        logic [COLS+1:0] mp;
        logic [COLS+1:0] bp;
        logic [3:0]      n;
        ap = {1'b0, above_reg, 1'b0};
        mp = {1'b0, cur_reg, 1'b0};
        bp = {1'b0, below, 1'b0};
        next_row = '0;
        for (int c = 0; c < COLS; c++)
        begin
            n = {3'b0, ap[c]} + {3'b0, ap[c+1]} + {3'b0, ap[c+2]}
              + {3'b0, mp[c]} + {3'b0, mp[c+2]}
              + {3'b0, bp[c]} + {3'b0, bp[c+1]} + {3'b0, bp[c+2]};
            next_row[c] = (n == 4'd3) || (mp[c+1] && (n == 4'd2));
        end
    end

    assign wr_data = cmd.use_item ? mod_row : next_row;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_vld_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_row_reg   <= row;
            item_col_reg   <= col;
            item_alive_reg <= alive;
        end
        if (cmd.clr_win)
        begin
            above_reg <= '0;
            cur_reg   <= '0;
        end
        else if (cmd.shift)
        begin
            above_reg <= cur_reg;
            cur_reg   <= rd_data;
        end
    end

    // output register, one row per transaction
    assign rd_wide   = {16'b0, rd_data};
    assign ocnt_wide = {4'b0, ocnt};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_idx_reg  <= ocnt_wide[3:0];
            out_bits_reg <= rd_wide[15:0];
            out_last_reg <= cmd.out_last;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.row_index = out_idx_reg;
    assign result.row_bits  = out_bits_reg;
    assign result.last      = out_last_reg;

endmodule

>>> rtl/life_automaton_grid_step.sv
// Game of Life (B3/S23) on a ROWS x COLS grid of one-bit cells, all dead after reset, with
// dead cells assumed beyond the border. Each item transaction is a cell write, an emit of
// every row as one result transaction each (last marks the final row), or one generation
// advanced in place. The grid sits in a one-read, one-write row memory. A write is a
// read-modify-write of one row (none when out of range), an emit reads every row in turn
// and waits while the output register is full, an advance sweeps every row, and an unused
// kind does nothing. The next item is taken once the item before is done, even while the
// last emitted row still waits in the output register.
module life_automaton_grid_step #(
    parameter int ROWS = 16,
    parameter int COLS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    lags_item_if.sink    item,
    lags_result_if.source result
);
    import lags_pkg::*;

    localparam int CNT_W = $clog2(ROWS + 2);
    localparam int RW    = $clog2(ROWS);

    cmd_t             cmd;
    stat_t            st;
    logic [CNT_W-1:0] cnt;
    logic [RW-1:0]    ocnt;
    logic             ready;

    assign item.ready = ready;

    lags_ctrl #(
        .ROWS (ROWS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .valid (item.valid),
        .ready (ready),
        .st    (st),
        .cmd   (cmd),
        .cnt   (cnt),
        .ocnt  (ocnt)
    );

    lags_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .kind   (item.kind),
        .row    (item.row),
        .col    (item.col),
        .alive  (item.alive),
        .cmd    (cmd),
        .cnt    (cnt),
        .ocnt   (ocnt),
        .st     (st),
        .result (result)
    );

endmodule
